// ----- hw/rtl/hba_pkg.sv -----
// shared types, constants and helper functions of the bitmap allocator
`timescale 1ns / 1ps

package hba_pkg;

  localparam int TREE_LEVELS_DEF = 3;
  localparam int WORD_W          = 64;
  localparam int SLOT_W          = 6;
  localparam int ID_W            = 18;
  localparam int LIMIT_W         = 19;
  localparam int MAX_LEVELS      = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 19'd262144;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_CLAIM = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_DUP   = 2'd3
  } status_t;

  // first word of a tree level: sum of 64^k for k below the level
  function automatic longint unsigned level_base(input int lvl);
    longint unsigned acc;
    acc = 0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if (k < lvl) begin
        acc = acc + (longint'(1) << (SLOT_W * k));
      end
    end
    return acc;
  endfunction

  // priority encoder, lowest set bit
  function automatic logic [SLOT_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
    logic [SLOT_W-1:0] pos;
    pos = SLOT_W'(WORD_W - 1);
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (w[b]) begin
        pos = SLOT_W'(b);
      end
    end
    return pos;
  endfunction

endpackage

// ----- hw/rtl/hba_req_if.sv -----
// request channel of the bitmap allocator
`timescale 1ns / 1ps

interface hba_req_if;
  import hba_pkg::*;

  logic              valid;
  logic              ready;
  mode_t             mode;
  logic [ID_W-1:0]   segment_id;

  modport source (output valid, output mode, output segment_id, input ready);
  modport sink   (input valid, input mode, input segment_id, output ready);
endinterface

// ----- hw/rtl/hba_rsp_if.sv -----
// response channel of the bitmap allocator
`timescale 1ns / 1ps

interface hba_rsp_if;
  import hba_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [ID_W-1:0]   result_id;
  logic              is_free;

  modport source (output valid, output status, output result_id, output is_free,
                  input ready);
  modport sink   (input valid, input status, input result_id, input is_free,
                  output ready);
endinterface

// ----- hw/rtl/hba_ram.sv -----
// generic single-port ram with registered read
`timescale 1ns / 1ps

module hba_ram #(
  parameter int WIDTH = 64,
  parameter longint unsigned DEPTH = 4161,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/hierarchical_bitmap_allocator.sv -----
// top level of the hierarchical 64-ary bitmap segment id allocator
`timescale 1ns / 1ps
// allocate first free: read each level's word on the way down and take the lowest free slot,
//   then update each level on the way up until a word stays non-empty
// free / allocate id: leaf word read, checked and updated, then parents as needed; query: leaf only
// throughput: one request at a time, set by the single ram port (one word read or write)
// reset: state, limit and handshakes cleared at once, then a clearing pass fills every
//   bitmap word with ones, one word a cycle, no request taken

module hierarchical_bitmap_allocator #(
  parameter int TREE_LEVELS = hba_pkg::TREE_LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [hba_pkg::LIMIT_W-1:0] cfg_wdata,
  hba_req_if.sink                     in_req,
  hba_rsp_if.source                   out_rsp
);
  import hba_pkg::*;

  // tree geometry
  localparam int NODE_W = SLOT_W * TREE_LEVELS;
  localparam longint unsigned WORD_COUNT = ((64'd1 << NODE_W) - 64'd1) / 64'd63;
  localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int LVL_W  = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;
  localparam int CMP_W  = ((NODE_W > LIMIT_W) ? NODE_W : LIMIT_W) + 1;

  localparam logic [LVL_W-1:0]  LEAF_LVL  = LVL_W'(TREE_LEVELS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORD_COUNT - 64'd1);
  localparam logic [CMP_W-1:0]  CAPACITY  = CMP_W'(1) << NODE_W;

  typedef enum logic [2:0] {
    S_CLEAR,   // fill the bitmap ram with ones after reset
    S_IDLE,
    S_DN_RD,   // descent: read the word on the path
    S_DN_WT,   // descent: pick the lowest free slot
    S_UP_RD,   // ascent: read the word of this level
    S_UP_WT,   // ascent: check leaf, update word, decide whether to go on
    S_DONE     // response held until taken
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  mode_t             mode_r, mode_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic              leaf_r, leaf_nxt;
  status_t           status_r, status_nxt;
  logic [ID_W-1:0]   rid_r, rid_nxt;
  logic              isf_r, isf_nxt;

  // ram port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic [ADDR_W-1:0] base_addr;
  logic [NODE_W-1:0] word_idx;
  logic [WORD_W-1:0] bit_mask;
  logic [WORD_W-1:0] word_set;
  logic [WORD_W-1:0] word_clr;
  logic              leaf_bit;
  logic              set_op;
  logic [CMP_W-1:0]  id_ext;
  logic              id_ok;
  logic [NODE_W-1:0] idx_down;
  logic [CMP_W-1:0]  idx_ext;

  hba_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (WORD_COUNT),
    .ADDR_W (ADDR_W)
  ) u_tree_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // word address: level base plus prefix of the id above this level
  assign base_addr = ADDR_W'(level_base(int'(lvl_r)));
  assign word_idx  = (state_r == S_DN_RD || state_r == S_DN_WT) ? node_r
                                                                : (node_r >> SLOT_W);
  assign ram_addr  = (state_r == S_CLEAR) ? sweep_r : (base_addr + ADDR_W'(word_idx));

  assign bit_mask  = WORD_W'(1) << node_r[SLOT_W-1:0];
  assign word_set  = ram_rdata | bit_mask;
  assign word_clr  = ram_rdata & ~bit_mask;
  assign leaf_bit  = |(ram_rdata & bit_mask);
  assign set_op    = (mode_r == MODE_FREE);

  // request id range check against the limit and the tree capacity
  assign id_ext    = CMP_W'(in_req.segment_id);
  assign id_ok     = (id_ext < CMP_W'(limit_r)) && (id_ext < CAPACITY);

  // next prefix on the way down
  assign idx_down  = NODE_W'({node_r, lowest_bit(ram_rdata)});
  assign idx_ext   = CMP_W'(idx_down);

  always_comb begin
    state_nxt  = state_r;
    sweep_nxt  = sweep_r;
    limit_nxt  = limit_r;
    mode_nxt   = mode_r;
    node_nxt   = node_r;
    lvl_nxt    = lvl_r;
    leaf_nxt   = leaf_r;
    status_nxt = status_r;
    rid_nxt    = rid_r;
    isf_nxt    = isf_r;
    ram_we     = 1'b0;
    ram_wdata  = word_clr;

    if (cfg_we) begin
      limit_nxt = cfg_wdata;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
        if (sweep_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_req.valid) begin
          mode_nxt   = in_req.mode;
          rid_nxt    = in_req.segment_id;
          isf_nxt    = 1'b0;
          status_nxt = ST_OK;
          if (in_req.mode == MODE_ALLOC) begin
            node_nxt  = '0;
            lvl_nxt   = '0;
            state_nxt = S_DN_RD;
          end else if (!id_ok) begin
            status_nxt = ST_RANGE;
            state_nxt  = S_DONE;
          end else begin
            node_nxt  = NODE_W'(id_ext);
            lvl_nxt   = LEAF_LVL;
            leaf_nxt  = 1'b1;
            state_nxt = S_UP_RD;
          end
        end
      end

      S_DN_RD: begin
        state_nxt = S_DN_WT;
      end

      S_DN_WT: begin
        if (ram_rdata == '0) begin
          // no free slot left on the path: the tree is full
          status_nxt = ST_FULL;
          rid_nxt    = '0;
          state_nxt  = S_DONE;
        end else if (lvl_r == LEAF_LVL) begin
          if (idx_ext < CMP_W'(limit_r)) begin
            node_nxt  = idx_down;
            rid_nxt   = ID_W'(idx_ext);
            leaf_nxt  = 1'b1;
            state_nxt = S_UP_RD;
          end else begin
            // lowest free id lies at or above the limit
            status_nxt = ST_FULL;
            rid_nxt    = '0;
            state_nxt  = S_DONE;
          end
        end else begin
          node_nxt  = idx_down;
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = S_DN_RD;
        end
      end

      S_UP_RD: begin
        state_nxt = S_UP_WT;
      end

      S_UP_WT: begin
        priority if (leaf_r && mode_r == MODE_QUERY) begin
          isf_nxt   = leaf_bit;
          state_nxt = S_DONE;
        end else if (leaf_r && set_op && leaf_bit) begin
          status_nxt = ST_DUP;
          state_nxt  = S_DONE;
        end else if (leaf_r && !set_op && !leaf_bit) begin
          status_nxt = ST_DUP;
          state_nxt  = S_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = set_op ? word_set : word_clr;
          leaf_nxt  = 1'b0;
          // clearing stops where the word keeps a free slot
          if ((!set_op && word_clr != '0) || lvl_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            lvl_nxt   = lvl_r - 1'b1;
            node_nxt  = node_r >> SLOT_W;
            state_nxt = S_UP_RD;
          end
        end
      end

      S_DONE: begin
        if (out_rsp.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sweep_r <= '0;
      limit_r <= LIMIT_RESET;
      leaf_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      limit_r <= limit_nxt;
      leaf_r  <= leaf_nxt;
    end
    mode_r   <= mode_nxt;
    node_r   <= node_nxt;
    lvl_r    <= lvl_nxt;
    status_r <= status_nxt;
    rid_r    <= rid_nxt;
    isf_r    <= isf_nxt;
  end

  assign in_req.ready      = (state_r == S_IDLE);
  assign out_rsp.valid     = (state_r == S_DONE);
  assign out_rsp.status    = status_r;
  assign out_rsp.result_id = rid_r;
  assign out_rsp.is_free   = isf_r;

endmodule

// ----- sim/tb_top.sv -----
// testbench for the bitmap allocator: directed and random requests checked against a tree model
`timescale 1ns / 1ps

module tb_top;
  import hba_pkg::*;

  localparam int LEVELS        = TREE_LEVELS_DEF;
  localparam int ID_SPACE      = 1 << (SLOT_W * LEVELS);
  localparam int MAP_WORDS     = (ID_SPACE - 1) / (WORD_W - 1);
  // margin after the last response, so this covers a request still in flight
  localparam int SETTLE_CYCLES = 24;
  // clearing pass, ~800 requests with full gaps and stalls, one long hold, many times over
  localparam int LIMIT_CYCLES  = 400000;

  typedef struct {
    status_t           status;
    logic [ID_W-1:0]   result_id;
    logic              is_free;
  } alloc_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [LIMIT_W-1:0]  cfg_wdata;

  hba_req_if req_ch();
  hba_rsp_if rsp_ch();

  hierarchical_bitmap_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // tree model: one bit per node, set while something below it is free
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0]  free_bits [MAP_WORDS];
  logic [LIMIT_W-1:0] seg_limit;
  alloc_result_t      pending_results [$];

  int  mismatches = 0;
  bit  idle_on    = 1'b0;   // random gaps on both sides
  bit  hold_req   = 1'b0;   // ask the response side for one long hold-off
  int  hold_len   = 0;

  // first word of a level: 64^0 + ... + 64^(lvl-1)
  function automatic int unsigned first_word(input int lvl);
    return ((1 << (SLOT_W * lvl)) - 1) / (WORD_W - 1);
  endfunction

  function automatic bit id_in_range(input int unsigned id);
    return id < seg_limit;
  endfunction

  function automatic bit leaf_free(input int unsigned id);
    return free_bits[first_word(LEVELS - 1) + (id >> SLOT_W)][id % WORD_W];
  endfunction

  // clear the leaf bit, then clear parents only while the word below went empty
  function automatic void take_segment(input int unsigned id);
    int unsigned node;
    int unsigned wi;
    node = id;
    for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
      wi = first_word(lvl) + (node >> SLOT_W);
      free_bits[wi][node % WORD_W] = 1'b0;
      if (free_bits[wi] != '0) break;
      node = node >> SLOT_W;
    end
  endfunction

  // updates the tree for one request and returns the response it should give
  function automatic alloc_result_t apply_request(input mode_t op, input logic [ID_W-1:0] seg);
    alloc_result_t     r;
    int unsigned       prefix;
    int unsigned       node;
    int                slot;
    logic [WORD_W-1:0] w;
    bit                exhausted;
    r.status    = ST_OK;
    r.result_id = seg;
    r.is_free   = 1'b0;
    if (op == MODE_ALLOC) begin
      // walk down taking the lowest set bit at each level
      prefix    = 0;
      exhausted = 1'b0;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
        if (!exhausted) begin
          w = free_bits[first_word(lvl) + prefix];
          if (w == '0) begin
            exhausted = 1'b1;
          end else begin
            slot = WORD_W - 1;
            for (int b = WORD_W - 1; b >= 0; b--) begin
              if (w[b]) slot = b;
            end
            prefix = (prefix << SLOT_W) | slot;
          end
        end
      end
      // lowest free id at or past the limit counts as full, nothing changes
      if (exhausted || !id_in_range(prefix)) begin
        r.status    = ST_FULL;
        r.result_id = '0;
      end else begin
        take_segment(prefix);
        r.result_id = ID_W'(prefix);
      end
    end else if (!id_in_range(seg)) begin
      r.status = ST_RANGE;
    end else if (op == MODE_FREE) begin
      if (leaf_free(seg)) begin
        r.status = ST_DUP;
      end else begin
        // freeing marks every level on the path
        node = seg;
        for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
          free_bits[first_word(lvl) + (node >> SLOT_W)][node % WORD_W] = 1'b1;
          node = node >> SLOT_W;
        end
      end
    end else if (op == MODE_CLAIM) begin
      if (!leaf_free(seg)) r.status = ST_DUP;
      else take_segment(seg);
    end else begin
      r.is_free = leaf_free(seg);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: drive at the falling edge, see the handshake at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_request(input mode_t op, input logic [ID_W-1:0] seg);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid      = 1'b1;
    req_ch.mode       = op;
    req_ch.segment_id = seg;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(apply_request(op, seg));
  endtask

  // stop offering, wait until every response is back, then let the block settle
  task automatic wait_for_drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    seg_limit = value;
  endtask

  // ---------------------------------------------------------------------------
  // response side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    rsp_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_ch.ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_req     = 1'b0;
        rsp_ch.ready = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // every accepted response is matched against the oldest outstanding prediction
  always @(posedge clk) begin : check_responses
    alloc_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: response with no request outstanding, got status %0d id %0d free %0d",
                 $time, rsp_ch.status, rsp_ch.result_id, rsp_ch.is_free);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.result_id !== want.result_id) begin
          $display("%0t: result_id expected %0d, got %0d",
                   $time, want.result_id, rsp_ch.result_id);
          mismatches++;
        end
        if (rsp_ch.is_free !== want.is_free) begin
          $display("%0t: is_free expected %0d, got %0d", $time, want.is_free, rsp_ch.is_free);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // fresh tree at the reset limit: extremes of the id, every mode, both duplicates
  task automatic test_reset_state();
    send_request(MODE_QUERY, '0);
    send_request(MODE_QUERY, '1);
    send_request(MODE_ALLOC, '1);      // id field ignored here
    send_request(MODE_ALLOC, '0);
    send_request(MODE_QUERY, '0);
    send_request(MODE_FREE,  '0);
    send_request(MODE_FREE,  '0);      // already free
    send_request(MODE_CLAIM, '1);
    send_request(MODE_CLAIM, '1);      // already allocated
    send_request(MODE_QUERY, '1);
    send_request(MODE_FREE,  '1);
    send_request(MODE_ALLOC, '0);
    wait_for_drain();
  endtask

  // limit of one, of zero, all ones, and a limit that cuts off the lowest free id
  task automatic test_limit_edges();
    set_limit(LIMIT_W'(1));
    send_request(MODE_ALLOC, '0);      // lowest free lies past the limit
    send_request(MODE_QUERY, '0);
    send_request(MODE_QUERY, ID_W'(1));
    send_request(MODE_FREE,  ID_W'(1));
    wait_for_drain();
    set_limit('0);                     // nothing is valid
    send_request(MODE_ALLOC, '0);
    send_request(MODE_QUERY, '0);
    send_request(MODE_CLAIM, '0);
    wait_for_drain();
    set_limit('1);                     // beyond the id range, whole tree valid
    send_request(MODE_CLAIM, '1);
    send_request(MODE_QUERY, '1);
    send_request(MODE_FREE,  '1);
    wait_for_drain();
    set_limit(LIMIT_W'(3));
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    wait_for_drain();
  endtask

  // mixed traffic in a small id window, with alloc runs long enough to empty leaf words
  task automatic test_random_traffic(input int count);
    int          sent;
    int          burst;
    int          pick;
    int unsigned near;
    logic [ID_W-1:0] seg;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 19) == 0) begin
        burst = $urandom_range(20, 70);
        repeat (burst) send_request(MODE_ALLOC, ID_W'($urandom));
        sent += burst;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          seg = ID_W'($urandom_range(0, 255));
        end else if (pick < 8 && seg_limit != 0) begin
          // last valid id or first rejected one
          near = seg_limit - 1 + $urandom_range(0, 1);
          if (near >= ID_SPACE) near = ID_SPACE - 1;
          seg = ID_W'(near);
        end else begin
          seg = ID_W'($urandom);
        end
        send_request(mode_t'($urandom_range(0, 3)), seg);
        sent++;
      end
    end
    wait_for_drain();
  endtask

  // response side holds off while requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    bit was_idle;
    was_idle = idle_on;
    idle_on  = 1'b0;
    hold_len = 300;
    hold_req = 1'b1;
    repeat (12) send_request(mode_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 127)));
    wait_for_drain();
    idle_on = was_idle;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_ALLOC;
    req_ch.segment_id = '0;
    foreach (free_bits[i]) free_bits[i] = '1;
    seg_limit = LIMIT_RESET;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // the block runs its clearing pass first; the handshake holds us off until done
    test_reset_state();
    test_limit_edges();

    idle_on = 1'b1;
    set_limit(LIMIT_RESET);
    test_random_traffic(200);

    // small limit, so alloc runs keep hitting full
    set_limit(LIMIT_W'(96));
    test_random_traffic(120);
    test_output_backpressure();

    set_limit(LIMIT_W'($urandom_range(1, ID_SPACE)));
    test_random_traffic(120);

    set_limit(LIMIT_W'(64));
    test_random_traffic(100);

    // last stretch runs without gaps on either side
    idle_on = 1'b0;
    set_limit(LIMIT_RESET);
    test_random_traffic(150);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
